/* rtl/ustrap_pkg.sv */
// ----------------------------------------------------------------------------
// ustrap_pkg
// Shared types and constants for the two-gate ultrasonic speed trap.
// ----------------------------------------------------------------------------
package ustrap_pkg;

  localparam int TICKS_W   = 16;
  localparam int TIME_W    = 32;
  localparam int DIST_W    = 11;
  localparam int THR_W     = 11;
  localparam int SPACING_W = 10;
  localparam int SLOPE_W   = 10;
  localparam int TONE_W    = 16;
  localparam int SPEED_W   = 18;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_DROP_THR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPACING  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOPE    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE     = 2'd3;

  localparam logic [THR_W-1:0]     RST_DROP_THR = 11'd40;
  localparam logic [SPACING_W-1:0] RST_SPACING  = 10'd300;
  localparam logic [SLOPE_W-1:0]   RST_SLOPE    = 10'd150;
  localparam logic [TONE_W-1:0]    RST_BASE     = 16'd200;

  // Divide by 58 as a multiply by a rounded-up reciprocal: exact for any
  // 16-bit operand since 65535 * 24 stays below 2^22.
  localparam int              CM_SHIFT = 22;
  localparam int              CM_PROD_W = 33;
  localparam logic [16:0]     CM_RECIP = 17'd72316;

  localparam logic [SPEED_W-1:0] SPEED_SAT = 18'd261888;
  localparam logic [TONE_W-1:0]  TONE_SAT  = 16'hFFFF;

  localparam logic [1:0] NO_PAIR = 2'd3;

  // Shared serial divider geometry.
  localparam int DIV_NUM_W = 20;
  localparam int DIV_DEN_W = 32;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

  typedef struct packed {
    logic               pair_index;
    logic [TICKS_W-1:0] echo_ticks_first;
    logic [TICKS_W-1:0] echo_ticks_second;
    logic [TIME_W-1:0]  time_ms;
  } in_t;

  typedef struct packed {
    logic               drop_alert;
    logic               speed_valid;
    logic [TIME_W-1:0]  elapsed_ms;
    logic [SPEED_W-1:0] speed_q8;
    logic [TONE_W-1:0]  tone_hz;
    logic               elapsed_zero;
    logic [DIST_W-1:0]  distance_first_cm;
    logic [DIST_W-1:0]  distance_second_cm;
  } out_t;

  typedef struct packed {
    logic [DIST_W-1:0] first;
    logic [DIST_W-1:0] second;
  } dist_pair_t;

endpackage

/* rtl/ustrap_div.sv */
// ----------------------------------------------------------------------------
// ustrap_div
// Restoring shift-subtract divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ustrap_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [ustrap_pkg::DIV_NUM_W-1:0]    num,
  input  logic [ustrap_pkg::DIV_DEN_W-1:0]    den,
  output logic                                done,
  output logic [ustrap_pkg::DIV_NUM_W-1:0]    quot
);

  localparam int NUM_W = ustrap_pkg::DIV_NUM_W;
  localparam int DEN_W = ustrap_pkg::DIV_DEN_W;
  localparam int CNT_W = ustrap_pkg::DIV_CNT_W;

  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [NUM_W-1:0] quot_r, quot_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;

  always_comb begin
    trial    = {rem_r, quot_r[NUM_W-1]};
    diff     = trial - {1'b0, den_r};
    fits     = (trial >= {1'b0, den_r});
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quot_nxt = quot_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      den_nxt  = den;
      quot_nxt = num;
      cnt_nxt  = CNT_W'(NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // The partial remainder always stays below the divisor, so it fits in DEN_W bits.
      rem_nxt  = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quot_nxt = {quot_r[NUM_W-2:0], fits};
      cnt_nxt  = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    quot_r <= quot_nxt;
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

/* rtl/ultrasonic_two_gate_speed_trap.sv */
// ----------------------------------------------------------------------------
// ultrasonic_two_gate_speed_trap
// Drop detection on sensor pairs and two-gate speed and tone computation.
// ----------------------------------------------------------------------------
// Each input item is one finished measurement of a sensor pair: two echo
// widths in 4 us ticks, the pair index and a millisecond timestamp. For each
// item the block returns exactly one result item with both distances in cm,
// the drop alert and, when this alert closes a two-gate measurement, the
// elapsed time, the speed in 1/256 m/s and the buzzer tone.
// Both channels use valid/ready. The input side takes one item at a time.
// An item that closes no measurement, or whose two alerts fall in the same
// millisecond, passes through S_CM_A, S_CM_B, S_EVAL and S_DONE before its
// result is shown. Any other closing item goes twice through the shared
// 20-step serial divider (speed in S_SPD, then tone in S_TONE) on its way
// to S_DONE. A new item is taken as soon as the sequencer is back in idle,
// so the block does not take a new item before it is through with the last.
// The result sits in an output register, so the next item may be accepted
// while the receiver stalls; only the final hand-off of that next item waits
// until the output register has been taken. Synchronous reset restores the
// register defaults, clears the stored distances and disarms the trap. The
// user must see that configuration is written through cfg_we, cfg_index
// and cfg_wdata only while no item is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module ultrasonic_two_gate_speed_trap #(
  parameter int SENSOR_COUNT = 4
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  ustrap_pkg::in_t                      in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output ustrap_pkg::out_t                     out_data,
  input  logic                                 cfg_we,
  input  logic [ustrap_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ustrap_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  // Only the second pair can fall outside the sensor array.
  localparam bit HAS_PAIR1 = (SENSOR_COUNT >= 4);

  localparam int DIST_W    = ustrap_pkg::DIST_W;
  localparam int TIME_W    = ustrap_pkg::TIME_W;
  localparam int NUM_W     = ustrap_pkg::DIV_NUM_W;
  localparam int SPEED_W   = ustrap_pkg::SPEED_W;
  localparam int TONE_W    = ustrap_pkg::TONE_W;
  localparam int PROD_W    = ustrap_pkg::SPACING_W + ustrap_pkg::SLOPE_W;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_CM_A = 7'b0000010,
    S_CM_B = 7'b0000100,
    S_EVAL = 7'b0001000,
    S_SPD  = 7'b0010000,
    S_TONE = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [ustrap_pkg::THR_W-1:0]     thr_r;
  logic [ustrap_pkg::SPACING_W-1:0] spacing_r;
  logic [ustrap_pkg::SLOPE_W-1:0]   slope_r;
  logic [TONE_W-1:0]                base_r;

  // Trap state.
  ustrap_pkg::dist_pair_t prev_r [2];
  ustrap_pkg::dist_pair_t prev_row;
  logic [TIME_W-1:0]      armed_time_r, armed_time_nxt;
  logic [1:0]             armed_pair_r, armed_pair_nxt;

  // Item in flight and its result under construction.
  ustrap_pkg::in_t    item_r, item_nxt;
  ustrap_pkg::out_t   res_r, res_nxt;
  logic [PROD_W-1:0]  tone_prod_r, tone_prod_nxt;
  logic               out_valid_r, out_valid_nxt;
  ustrap_pkg::out_t   out_data_r, out_data_nxt;

  // Distance conversion: ((ticks * 4) mod 65536) / 58 via reciprocal.
  logic [ustrap_pkg::TICKS_W-1:0]   cm_ticks;
  logic [ustrap_pkg::TICKS_W-1:0]   cm_scaled;
  logic [ustrap_pkg::CM_PROD_W-1:0] cm_prod;
  logic [DIST_W-1:0]                cm_dist;

  // Evaluation signals.
  logic              pair_ok;
  logic              fell_first;
  logic              fell_second;
  logic              alert;
  logic              measure;
  logic [TIME_W-1:0] elapsed;
  logic              row_we;

  // Shared divider.
  logic                           div_start;
  logic [NUM_W-1:0]               div_num;
  logic [ustrap_pkg::DIV_DEN_W-1:0] div_den;
  logic                           div_done;
  logic [NUM_W-1:0]               div_quot;
  logic [NUM_W:0]                 tone_sum;

  assign cm_ticks  = (state_r == S_CM_A) ? item_r.echo_ticks_first
                                         : item_r.echo_ticks_second;
  assign cm_scaled = {cm_ticks[ustrap_pkg::TICKS_W-3:0], 2'b00};
  assign cm_prod   = ustrap_pkg::CM_PROD_W'(cm_scaled)
                   * ustrap_pkg::CM_PROD_W'(ustrap_pkg::CM_RECIP);
  assign cm_dist   = cm_prod[ustrap_pkg::CM_SHIFT +: DIST_W];

  // A sensor counts as dropped when its distance fell by strictly more than
  // the threshold since the pair's previous measurement.
  assign prev_row    = prev_r[item_r.pair_index];
  assign pair_ok     = !item_r.pair_index || HAS_PAIR1;
  assign fell_first  = (prev_row.first > res_r.distance_first_cm) &&
                       ((prev_row.first - res_r.distance_first_cm) > thr_r);
  assign fell_second = (prev_row.second > res_r.distance_second_cm) &&
                       ((prev_row.second - res_r.distance_second_cm) > thr_r);
  assign alert       = pair_ok && (fell_first || fell_second);
  // Armed means a nonzero stored time from the other pair.
  assign measure     = alert && (armed_time_r != '0) &&
                       (armed_pair_r != {1'b0, item_r.pair_index});
  assign elapsed     = item_r.time_ms - armed_time_r;
  assign row_we      = (state_r == S_EVAL) && pair_ok;

  // Speed is divided first, then the tone; the divisor is the elapsed time.
  assign div_start = ((state_r == S_EVAL) && measure && (elapsed != '0)) ||
                     ((state_r == S_SPD) && div_done);
  assign div_num   = (state_r == S_EVAL)
                   ? NUM_W'({spacing_r, 8'h00})
                   : NUM_W'(tone_prod_r);
  assign div_den   = (state_r == S_EVAL) ? elapsed : res_r.elapsed_ms;
  assign tone_sum  = (NUM_W + 1)'(div_quot) + (NUM_W + 1)'(base_r);

  ustrap_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_comb begin
    state_nxt      = state_r;
    item_nxt       = item_r;
    res_nxt        = res_r;
    tone_prod_nxt  = tone_prod_r;
    armed_time_nxt = armed_time_r;
    armed_pair_nxt = armed_pair_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          state_nxt = S_CM_A;
        end
      end
      S_CM_A: begin
        res_nxt                   = '0;
        res_nxt.distance_first_cm = cm_dist;
        state_nxt                 = S_CM_B;
      end
      S_CM_B: begin
        res_nxt.distance_second_cm = cm_dist;
        state_nxt                  = S_EVAL;
      end
      S_EVAL: begin
        res_nxt.drop_alert = alert;
        tone_prod_nxt      = PROD_W'(spacing_r) * PROD_W'(slope_r);
        if (alert) begin
          if (measure) begin
            armed_time_nxt = '0;
            armed_pair_nxt = ustrap_pkg::NO_PAIR;
          end else begin
            armed_time_nxt = item_r.time_ms;
            armed_pair_nxt = {1'b0, item_r.pair_index};
          end
        end
        if (measure) begin
          res_nxt.speed_valid = 1'b1;
          res_nxt.elapsed_ms  = elapsed;
        end
        if (measure && (elapsed == '0)) begin
          // Two alerts in the same millisecond: saturate speed and tone.
          res_nxt.elapsed_zero = 1'b1;
          res_nxt.speed_q8     = ustrap_pkg::SPEED_SAT;
          res_nxt.tone_hz      = ustrap_pkg::TONE_SAT;
          state_nxt            = S_DONE;
        end else if (measure) begin
          state_nxt = S_SPD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SPD: begin
        if (div_done) begin
          res_nxt.speed_q8 = div_quot[SPEED_W-1:0];
          state_nxt        = S_TONE;
        end
      end
      S_TONE: begin
        if (div_done) begin
          res_nxt.tone_hz = (tone_sum[NUM_W:TONE_W] != '0)
                          ? ustrap_pkg::TONE_SAT
                          : tone_sum[TONE_W-1:0];
          state_nxt       = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      armed_time_r <= '0;
      armed_pair_r <= ustrap_pkg::NO_PAIR;
      prev_r[0]    <= '0;
      prev_r[1]    <= '0;
      thr_r        <= ustrap_pkg::RST_DROP_THR;
      spacing_r    <= ustrap_pkg::RST_SPACING;
      slope_r      <= ustrap_pkg::RST_SLOPE;
      base_r       <= ustrap_pkg::RST_BASE;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      armed_time_r <= armed_time_nxt;
      armed_pair_r <= armed_pair_nxt;
      if (row_we) begin
        prev_r[item_r.pair_index] <= '{first:  res_r.distance_first_cm,
                                       second: res_r.distance_second_cm};
      end
      if (cfg_we) begin
        unique case (cfg_index)
          ustrap_pkg::CFG_DROP_THR: thr_r     <= cfg_wdata[ustrap_pkg::THR_W-1:0];
          ustrap_pkg::CFG_SPACING:  spacing_r <= cfg_wdata[ustrap_pkg::SPACING_W-1:0];
          ustrap_pkg::CFG_SLOPE:    slope_r   <= cfg_wdata[ustrap_pkg::SLOPE_W-1:0];
          ustrap_pkg::CFG_BASE:     base_r    <= cfg_wdata[TONE_W-1:0];
          default: begin
          end
        endcase
      end
    end
    item_r      <= item_nxt;
    res_r       <= res_nxt;
    tone_prod_r <= tone_prod_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/ustrap_chk.sv */
// ----------------------------------------------------------------------------
// ustrap_chk
// Port-level checks for the speed trap, bound to the top level.
// ----------------------------------------------------------------------------
module ustrap_chk (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input ustrap_pkg::out_t out_data
);

  // No result survives a reset.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A stalled result holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Without a completed measurement the speed fields are all zero.
  a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.speed_valid |->
      out_data.elapsed_ms == '0 && out_data.speed_q8 == '0 &&
      out_data.tone_hz == '0 && !out_data.elapsed_zero)
    else $error("speed fields set without a measurement");

  // Zero elapsed time saturates both speed and tone.
  a_zero_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.elapsed_zero |->
      out_data.speed_valid && out_data.elapsed_ms == '0 &&
      out_data.speed_q8 == ustrap_pkg::SPEED_SAT &&
      out_data.tone_hz == ustrap_pkg::TONE_SAT)
    else $error("zero elapsed time not saturated");

  // Only an alert can close a measurement.
  a_valid_alert: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.speed_valid |-> out_data.drop_alert)
    else $error("measurement without a drop alert");

endmodule

bind ultrasonic_two_gate_speed_trap ustrap_chk u_ustrap_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

/* test/ultrasonic_two_gate_speed_trap_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ultrasonic_two_gate_speed_trap_tb
// Self-checking bench for the two-gate ultrasonic speed trap.
// ----------------------------------------------------------------------------
// A queue of sensor-pair measurements feeds a valid/ready driver, and a
// clocked monitor checks every result item against a behavioral prediction of
// the trap. The stimulus starts with a directed walk through the corner cases
// and then runs long random phases under several register settings. The
// random phases are built mostly from far-then-near sequences that arm and
// close the trap. Both sides of the handshake idle at random.
// ----------------------------------------------------------------------------
module ultrasonic_two_gate_speed_trap_tb;
  import ustrap_pkg::*;

  localparam int SENSOR_COUNT = 4;
  localparam int MAX_CM       = 1129;
  // This many quiet cycles after the last result leave nothing in flight
  // inside the block, even behind the slowest item.
  localparam int SETTLE_CYCLES = 60;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;

  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  always #6 clk = ~clk;

  ultrasonic_two_gate_speed_trap #(
    .SENSOR_COUNT(SENSOR_COUNT)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Measurements waiting to be sent, and the results we expect back in order.
  in_t  pending_q[$];
  out_t expected_q[$];

  // Our own copy of the trap: registers, stored distances and the armed gate.
  logic [THR_W-1:0]     thr_reg;
  logic [SPACING_W-1:0] spacing_reg;
  logic [SLOPE_W-1:0]   slope_reg;
  logic [TONE_W-1:0]    base_reg;
  logic [DIST_W-1:0]    prev_dist [SENSOR_COUNT];
  logic [TIME_W-1:0]    armed_at;
  logic [1:0]           armed_by;

  // Handshake flags captured at the rising edge for the falling-edge drivers.
  logic in_took  = 1'b0;
  logic out_took = 1'b0;

  int mismatches   = 0;
  int n_results    = 0;
  int n_alerts     = 0;
  int n_speeds     = 0;
  int n_zero_gaps  = 0;
  int n_tone_sat   = 0;
  int items_queued = 0;

  // Threshold in force for the stimulus generator, so it can build real drops.
  int gen_thr = RST_DROP_THR;
  logic [TIME_W-1:0] now_ms = '0;

  // Echo width in 4 us ticks to centimetres: times four, wrapped to 16 bits,
  // divided by 58.
  function automatic logic [DIST_W-1:0] echo_cm(logic [TICKS_W-1:0] ticks);
    logic [15:0] scaled;
    scaled = {ticks[13:0], 2'b00};
    return DIST_W'(scaled / 16'd58);
  endfunction

  function automatic bit dropped(int unsigned was_cm, int unsigned now_cm);
    return was_cm > now_cm && (was_cm - now_cm) > thr_reg;
  endfunction

  // Computes the result of one measurement and advances the trap state.
  function automatic out_t predict_trap(in_t it);
    out_t            r;
    int unsigned     lo;
    logic [TIME_W-1:0] gap;
    longint unsigned tone_sum;
    r = '0;
    r.distance_first_cm  = echo_cm(it.echo_ticks_first);
    r.distance_second_cm = echo_cm(it.echo_ticks_second);
    lo = 2 * int'(it.pair_index);
    // A pair beyond the fitted sensors only reports its distances.
    if (lo + 1 < SENSOR_COUNT) begin
      r.drop_alert = dropped(prev_dist[lo], r.distance_first_cm) ||
                     dropped(prev_dist[lo + 1], r.distance_second_cm);
      if (r.drop_alert) begin
        if (armed_at != '0 && armed_by != {1'b0, it.pair_index}) begin
          // The second gate fired: work out the speed and disarm.
          gap = it.time_ms - armed_at;
          r.speed_valid = 1'b1;
          r.elapsed_ms  = gap;
          if (gap == '0) begin
            r.elapsed_zero = 1'b1;
            r.speed_q8     = SPEED_SAT;
            r.tone_hz      = TONE_SAT;
          end else begin
            r.speed_q8 = SPEED_W'((64'(spacing_reg) * 256) / gap);
            tone_sum   = (64'(spacing_reg) * slope_reg) / gap + base_reg;
            r.tone_hz  = (tone_sum > 64'hFFFF) ? TONE_SAT : TONE_W'(tone_sum);
          end
          armed_at = '0;
          armed_by = NO_PAIR;
        end else begin
          // First gate, or the same pair again: (re)arm. Arming at time zero
          // leaves the trap effectively unarmed.
          armed_at = it.time_ms;
          armed_by = {1'b0, it.pair_index};
        end
      end
      prev_dist[lo]     = r.distance_first_cm;
      prev_dist[lo + 1] = r.distance_second_cm;
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      if (mismatches < 10)
        $display("[%0t] mismatch in %s: expected %0d, got %0d", $realtime, name, want, got);
      mismatches++;
    end
  endtask

  // Monitor and predictor. Everything here reads values from before the
  // edge, so it does not care how the edge's events are ordered.
  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      thr_reg     = RST_DROP_THR;
      spacing_reg = RST_SPACING;
      slope_reg   = RST_SLOPE;
      base_reg    = RST_BASE;
      for (int i = 0; i < SENSOR_COUNT; i++) prev_dist[i] = '0;
      armed_at = '0;
      armed_by = NO_PAIR;
      in_took  <= 1'b0;
      out_took <= 1'b0;
    end else begin
      in_took  <= in_valid && in_ready;
      out_took <= out_valid && out_ready;
      if (out_valid && out_ready) begin
        n_results++;
        if (expected_q.size() == 0) begin
          if (mismatches < 10)
            $display("[%0t] result item arrived with nothing expected", $realtime);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          check_field("drop_alert", want.drop_alert, out_data.drop_alert);
          check_field("speed_valid", want.speed_valid, out_data.speed_valid);
          check_field("elapsed_ms", want.elapsed_ms, out_data.elapsed_ms);
          check_field("speed_q8", want.speed_q8, out_data.speed_q8);
          check_field("tone_hz", want.tone_hz, out_data.tone_hz);
          check_field("elapsed_zero", want.elapsed_zero, out_data.elapsed_zero);
          check_field("distance_first_cm", want.distance_first_cm,
                      out_data.distance_first_cm);
          check_field("distance_second_cm", want.distance_second_cm,
                      out_data.distance_second_cm);
          if (want.drop_alert) n_alerts++;
          if (want.speed_valid) n_speeds++;
          if (want.elapsed_zero) n_zero_gaps++;
          if (want.speed_valid && want.tone_hz == TONE_SAT) n_tone_sat++;
        end
      end
      if (in_valid && in_ready) expected_q.push_back(predict_trap(in_data));
      if (cfg_we) begin
        case (cfg_index)
          CFG_DROP_THR: thr_reg     = cfg_wdata[THR_W-1:0];
          CFG_SPACING:  spacing_reg = cfg_wdata[SPACING_W-1:0];
          CFG_SLOPE:    slope_reg   = cfg_wdata[SLOPE_W-1:0];
          CFG_BASE:     base_reg    = cfg_wdata[TONE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Input driver. A fresh idle gap is drawn at random with each item;
  // now and then it switches into a burst mode with no gaps at all.
  int send_gap   = 0;
  bit send_burst = 1'b0;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        in_data  <= pending_q.pop_front();
        in_valid <= 1'b1;
        if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
        send_gap = send_burst ? 0 : $urandom_range(0, 7);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver: after each result item it draws a random stall, again
  // with occasional stretches of no stalling.
  int stall_left  = 0;
  bit stall_burst = 1'b0;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_took) begin
        if ($urandom_range(0, 39) == 0) stall_burst = !stall_burst;
        stall_left = stall_burst ? 0 : $urandom_range(0, 7);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic push_item(bit pair, logic [TICKS_W-1:0] t1, logic [TICKS_W-1:0] t2,
                           logic [TIME_W-1:0] stamp);
    in_t it;
    it.pair_index        = pair;
    it.echo_ticks_first  = t1;
    it.echo_ticks_second = t2;
    it.time_ms           = stamp;
    pending_q.push_back(it);
    items_queued++;
  endtask

  // Any tick count that lands on the given distance, with random top bits
  // that the scaling wraps away.
  function automatic logic [TICKS_W-1:0] ticks_for(int cm);
    int lo_t;
    int hi_t;
    lo_t = (cm * 58 + 3) / 4;
    hi_t = (cm * 58 + 57) / 4;
    if (hi_t > 16383) hi_t = 16383;
    return {2'($urandom_range(0, 3)), 14'($urandom_range(lo_t, hi_t))};
  endfunction

  // A far reading followed by a near one on the same pair, so that the second
  // item raises an alert at t_alert whenever the threshold allows a drop.
  // The first sensor, the second or both may carry the drop.
  task automatic queue_drop(bit pair, logic [TIME_W-1:0] t_alert);
    int far_cm;
    int near_cm;
    int steady_cm;
    int which;
    if (gen_thr >= MAX_CM) begin
      far_cm  = $urandom_range(0, MAX_CM);
      near_cm = $urandom_range(0, MAX_CM);
    end else begin
      far_cm  = $urandom_range(gen_thr + 1, MAX_CM);
      near_cm = $urandom_range(0, far_cm - gen_thr - 1);
    end
    steady_cm = $urandom_range(0, MAX_CM);
    which     = $urandom_range(0, 2);
    push_item(pair, ticks_for(which == 1 ? steady_cm : far_cm),
              ticks_for(which == 0 ? steady_cm : far_cm), t_alert - $urandom_range(0, 50));
    push_item(pair, ticks_for(which == 1 ? steady_cm : near_cm),
              ticks_for(which == 0 ? steady_cm : near_cm), t_alert);
  endtask

  // Random phase: mostly complete two-gate passes, some lone alerts and some
  // plain noise with every field random.
  task automatic run_random(int count);
    int                goal;
    int                pick;
    bit                pair;
    bit                pair2;
    logic [TIME_W-1:0] t_arm;
    logic [TIME_W-1:0] gap;
    goal = items_queued + count;
    while (items_queued < goal) begin
      pick = $urandom_range(0, 99);
      pair = 1'($urandom_range(0, 1));
      if (pick < 70) begin
        t_arm = ($urandom_range(0, 49) == 0) ? '0 : now_ms + $urandom_range(1, 1000);
        queue_drop(pair, t_arm);
        // Usually the other pair closes the measurement; sometimes the same
        // pair fires again and just re-arms.
        pair2 = ($urandom_range(0, 4) == 0) ? pair : !pair;
        case ($urandom_range(0, 9))
          0:       gap = '0;
          1:       gap = $urandom_range(1, 3);
          2:       gap = $urandom();
          default: gap = $urandom_range(1, 5000);
        endcase
        queue_drop(pair2, t_arm + gap);
        now_ms = t_arm + gap;
      end else if (pick < 85) begin
        now_ms = now_ms + $urandom_range(0, 2000);
        queue_drop(pair, now_ms);
      end else begin
        push_item(pair, 16'($urandom()), 16'($urandom()), $urandom());
      end
    end
  endtask

  // Let the queue run dry and every result come back, then give the block
  // time to fall idle before the registers are touched.
  task automatic settle();
    while (pending_q.size() != 0 || in_valid || expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(int thr, int spacing, int slope, int base);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DROP_THR;
    cfg_wdata <= CFG_DATA_W'(thr);
    @(negedge clk);
    cfg_index <= CFG_SPACING;
    cfg_wdata <= CFG_DATA_W'(spacing);
    @(negedge clk);
    cfg_index <= CFG_SLOPE;
    cfg_wdata <= CFG_DATA_W'(slope);
    @(negedge clk);
    cfg_index <= CFG_BASE;
    cfg_wdata <= CFG_DATA_W'(base);
    @(negedge clk);
    cfg_we <= 1'b0;
    gen_thr = thr & 32'h7FF;
  endtask

  // Directed walk at the reset register values (threshold 40 cm).
  task automatic queue_directed();
    push_item(1'b0, 16'h0000, 16'h0000, 32'd0);      // zero echoes, nothing stored
    push_item(1'b1, 16'hFFFF, 16'hFFFF, 32'd5);      // all-ones ticks, maximum range
    push_item(1'b0, 16'd16383, 16'd16383, 32'd7);    // largest distance on pair 0
    // Drop on pair 0 at time zero: it arms with a zero time, so stays unarmed.
    push_item(1'b0, 16'h0000, 16'd16383, 32'd0);
    // Drop on pair 1 then arms the trap for real.
    push_item(1'b1, 16'h0000, 16'h0000, 32'd10);
    push_item(1'b0, 16'd16383, 16'd16383, 32'd20);
    // Pair 0 drops at the armed time itself (16384 ticks wrap to zero):
    // zero elapsed time, saturated speed and tone.
    push_item(1'b0, 16'h0000, 16'd16384, 32'd10);
    // Pair 1 arms, re-arms itself later, and pair 0 closes one ms on.
    push_item(1'b1, 16'd16383, 16'd16383, 32'd11);
    push_item(1'b1, 16'h0000, 16'd16383, 32'd100);
    push_item(1'b0, 16'd16383, 16'd16383, 32'd101);
    push_item(1'b1, 16'd16383, 16'd16383, 32'd102);
    push_item(1'b1, 16'd16383, 16'h0000, 32'd150);
    push_item(1'b0, 16'h0000, 16'h0000, 32'd151);
    // A fall of exactly the threshold does not count; one more centimetre does.
    push_item(1'b0, ticks_for(100), ticks_for(100), 32'd160);
    push_item(1'b0, ticks_for(60), ticks_for(100), 32'hFFFF_FFF0);
    push_item(1'b0, ticks_for(60), ticks_for(59), 32'hFFFF_FFF0);
    // Closing pass after the millisecond counter wrapped.
    push_item(1'b1, 16'd16383, 16'd16383, 32'hFFFF_FFF8);
    push_item(1'b1, 16'd16383, 16'h0000, 32'h0000_0010);
    now_ms = 32'h0000_0100;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    queue_directed();
    run_random(150);

    // Lowest register values, with spacing at one.
    settle();
    write_regs(0, 1, 0, 0);
    run_random(170);

    // Every data bit set: threshold beyond any possible drop, largest spacing,
    // slope and offset.
    settle();
    write_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_random(60);

    // Small threshold with large spacing, slope and base, so the tone often saturates.
    settle();
    write_regs(5, 1023, 1023, 65000);
    run_random(200);

    settle();
    write_regs($urandom_range(0, 300), $urandom_range(1, 1023), $urandom_range(0, 1023),
               $urandom_range(0, 65535));
    run_random(200);

    settle();
    write_regs($urandom_range(0, 300), $urandom_range(1, 1023), $urandom_range(0, 1023),
               $urandom_range(0, 65535));
    run_random(200);

    settle();
    $display("Sent %0d measurements over six register settings; %0d results checked.",
             items_queued, n_results);
    $display("Seen %0d drop alerts and %0d speed readings (%0d zero-time, %0d tone-limited).",
             n_alerts, n_speeds, n_zero_gaps, n_tone_sat);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("** ultrasonic_two_gate_speed_trap: PASSED **");
    end else begin
      $display("** ultrasonic_two_gate_speed_trap: FAILED **");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin
    #10_000_000;
    $display("Run did not finish in time; %0d results still expected.", expected_q.size());
    $display("** ultrasonic_two_gate_speed_trap: FAILED **");
    $finish;
  end

endmodule
